// File: rtl/core/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// shared constants, codes and types of the direct-mapped cache lookup
// ----------------------------------------------------------------------------
package dmc_pkg;

  // field widths of the request and response transactions
  localparam int unsigned CmdW     = 2;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned WdataW   = 16;
  localparam int unsigned KindW    = 3;
  localparam int unsigned SetOutW  = 3;
  localparam int unsigned TagOutW  = 28;
  localparam int unsigned DataOutW = 16;
  localparam int unsigned ByteW    = 8;

  // geometry defaults
  localparam int unsigned NumSetsDefault    = 8;
  localparam int unsigned BlockBytesDefault = 2;

  // a dump reports at most this many lines
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_DUMP  = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_HIT     = 3'd0,
    KIND_MISS    = 3'd1,
    KIND_EVICT   = 3'd2,
    KIND_WRITTEN = 3'd3,
    KIND_DUMP    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITE,
    ST_DUMP,
    ST_DUMP_END
  } state_e;

endpackage

// File: rtl/core/dmc_req_if.sv
// ----------------------------------------------------------------------------
// dmc_req_if
// request channel: command, byte address and write block
// ----------------------------------------------------------------------------
interface dmc_req_if
  import dmc_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [AddrW-1:0]  address;
  logic [WdataW-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  output ready);

endinterface

// File: rtl/core/dmc_rsp_if.sv
// ----------------------------------------------------------------------------
// dmc_rsp_if
// response channel: one reported line or lookup result per transaction
// ----------------------------------------------------------------------------
interface dmc_rsp_if
  import dmc_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [SetOutW-1:0]  set_index;
  logic [TagOutW-1:0]  line_tag;
  logic [DataOutW-1:0] line_data;
  logic [ByteW-1:0]    read_byte;
  logic                last;

  modport source (output valid, output kind, output set_index, output line_tag,
                  output line_data, output read_byte, output last, input ready);
  modport sink   (input valid, input kind, input set_index, input line_tag,
                  input line_data, input read_byte, input last, output ready);

endinterface

// File: rtl/core/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/direct_mapped_cache_lookup.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup
// direct-mapped cache directory with read, block write and dump commands
// ----------------------------------------------------------------------------
// Each line (valid bit, tag and block) lives in one entry of a single-port
// ram with a registered read, so every read or write is a read of the
// entry followed by the lookup state that decides, reports and, for a
// write, writes the entry back; a write that evicts a valid line with
// another tag reports the victim first and writes the entry back in the
// write state. Each result is loaded into the output register once that
// register is free. The next request is taken once the result has been
// loaded, so no new request is taken while one is in flight. A dump walks
// the sets one ram read per cycle while the output side does not stall,
// and reports at most 8 valid lines in set order, last on the final one.
// After reset a clearing pass invalidates every entry; no request is taken
// during it. NUM_SETS and BLOCK_BYTES must be powers of two: the offset is
// the low log2(BLOCK_BYTES) address bits, the set the next log2(NUM_SETS)
// bits and the tag the rest. At most two bytes of a block can be written,
// higher bytes read back as zero for blocks of up to eight bytes.
module direct_mapped_cache_lookup
  import dmc_pkg::*;
#(
  parameter int unsigned NUM_SETS    = NumSetsDefault,
  parameter int unsigned BLOCK_BYTES = BlockBytesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  dmc_req_if.sink   in_i,
  dmc_rsp_if.source out_o
);

  // address split
  localparam int unsigned OffW   = $clog2(BLOCK_BYTES);
  localparam int unsigned SetW   = $clog2(NUM_SETS);
  localparam int unsigned TagW   = AddrW - OffW - SetW;
  // at most two bytes of a block are stored, the rest reads as zero for blocks up to eight bytes
  localparam int unsigned DataW  = (8 * BLOCK_BYTES < DataOutW) ? 8 * BLOCK_BYTES : DataOutW;
  localparam int unsigned EntryW = 1 + TagW + DataW;
  localparam logic [SetW-1:0] LastSet = SetW'(NUM_SETS - 1);

  // control state
  state_e          state_q, state_d;
  logic [SetW-1:0] ptr_q, ptr_d;      // clearing and dump walk pointer
  logic [CntW-1:0] cnt_q, cnt_d;      // lines taken by the current dump
  logic            pend_q, pend_d;    // a dump line held until its last flag is known
  logic            out_valid_q;

  // latched request
  logic             lat_is_write_q;
  logic [AddrW-1:0] lat_addr_q;
  logic [DataW-1:0] lat_wdata_q;

  // held dump line
  logic             pend_load;
  logic [SetW-1:0]  pend_set_q;
  logic [TagW-1:0]  pend_tag_q;
  logic [DataW-1:0] pend_data_q;

  // output register
  logic                out_load;
  logic                out_free;
  kind_e               out_kind_q, out_kind_d;
  logic [SetOutW-1:0]  out_set_q, out_set_d;
  logic [TagOutW-1:0]  out_tag_q, out_tag_d;
  logic [DataOutW-1:0] out_data_q, out_data_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  // ram port
  logic              ram_we;
  logic              ram_re;
  logic [SetW-1:0]   ram_addr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic              in_acc;
  logic [SetW-1:0]   in_set;
  logic [SetW-1:0]   lat_set;
  logic [TagW-1:0]   lat_tag;
  logic [2:0]        lat_off;
  logic              r_valid;
  logic [TagW-1:0]   r_tag;
  logic [DataW-1:0]  r_data;
  logic [DataOutW-1:0] r_data_ext;
  logic [ByteW-1:0]  r_byte;
  logic              r_hit;
  logic              take;

  assign in_acc  = in_i.valid && in_i.ready;
  assign in_set  = SetW'(in_i.address >> OffW);
  assign lat_set = SetW'(lat_addr_q >> OffW);
  assign lat_tag = TagW'(lat_addr_q >> (OffW + SetW));
  // byte offset within the block, as the low three address bits allow
  assign lat_off = lat_addr_q[2:0] & 3'(BLOCK_BYTES - 1);

  // fields of the entry last read from the ram
  assign r_valid    = ram_rdata[EntryW-1];
  assign r_tag      = ram_rdata[DataW +: TagW];
  assign r_data     = ram_rdata[DataW-1:0];
  assign r_data_ext = DataOutW'(r_data);
  assign r_hit      = r_valid && (r_tag == lat_tag);
  assign take       = r_valid;

  always_comb begin
    priority if (lat_off == 3'd0) begin
      r_byte = r_data_ext[7:0];
    end else if (lat_off == 3'd1) begin
      r_byte = r_data_ext[15:8];
    end else begin
      r_byte = '0;
    end
  end

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || out_o.ready;

  dmc_ram #(
    .Width (EntryW),
    .Depth (NUM_SETS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // state register and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lat_is_write_q <= (in_i.command == CMD_WRITE);
      lat_addr_q     <= in_i.address;
      lat_wdata_q    <= DataW'(in_i.write_data);
    end
    if (pend_load) begin
      pend_set_q  <= ptr_q;
      pend_tag_q  <= r_tag;
      pend_data_q <= r_data;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_set_q  <= out_set_d;
      out_tag_q  <= out_tag_d;
      out_data_q <= out_data_d;
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  // next state, ram control and result selection
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_load  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = lat_set;
    ram_wdata  = {1'b1, lat_tag, lat_wdata_q};
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    out_kind_d = KIND_WRITTEN;
    out_set_d  = SetOutW'(lat_set);
    out_tag_d  = TagOutW'(lat_tag);
    out_data_d = DataOutW'(lat_wdata_q);
    out_byte_d = '0;
    out_last_d = 1'b1;

    unique case (state_q)
      ST_CLEAR: begin
        // invalidate one entry per cycle after reset
        ram_we    = 1'b1;
        ram_addr  = ptr_q;
        ram_wdata = '0;
        if (ptr_q == LastSet) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_addr   = in_set;
        if (in_acc) begin
          case (cmd_e'(in_i.command))
            CMD_READ, CMD_WRITE: begin
              ram_re  = 1'b1;
              state_d = ST_LOOKUP;
            end
            CMD_DUMP: begin
              ram_re   = 1'b1;
              ram_addr = '0;
              ptr_d    = '0;
              cnt_d    = '0;
              state_d  = ST_DUMP;
            end
            default: begin
              // unused code, dropped without a result
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!lat_is_write_q) begin
            out_kind_d = r_hit ? KIND_HIT : KIND_MISS;
            out_data_d = r_hit ? r_data_ext : '0;
            out_byte_d = r_hit ? r_byte : '0;
            state_d    = ST_IDLE;
          end else if (r_valid && (r_tag != lat_tag)) begin
            // report the victim first, write in ST_WRITE once the output register is free
            out_kind_d = KIND_EVICT;
            out_tag_d  = TagOutW'(r_tag);
            out_data_d = r_data_ext;
            out_last_d = 1'b0;
            state_d    = ST_WRITE;
          end else begin
            ram_we  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_WRITE: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_DUMP: begin
        // ram data is the entry at ptr_q, prefetch the next one
        ram_addr = ptr_q + 1'b1;
        if (!(take && pend_q && !out_free)) begin
          if (take) begin
            pend_load = 1'b1;
            pend_d    = 1'b1;
            cnt_d     = cnt_q + 1'b1;
            if (pend_q) begin
              // a later valid line exists, so the held one is not last
              out_load   = 1'b1;
              out_kind_d = KIND_DUMP;
              out_set_d  = SetOutW'(pend_set_q);
              out_tag_d  = TagOutW'(pend_tag_q);
              out_data_d = DataOutW'(pend_data_q);
              out_last_d = 1'b0;
            end
          end
          if ((ptr_q == LastSet) || (take && (cnt_q == CntW'(MaxResults - 1)))) begin
            state_d = ST_DUMP_END;
          end else begin
            ptr_d  = ptr_q + 1'b1;
            ram_re = 1'b1;
          end
        end
      end

      ST_DUMP_END: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_DUMP;
          out_set_d  = SetOutW'(pend_set_q);
          out_tag_d  = TagOutW'(pend_tag_q);
          out_data_d = DataOutW'(pend_data_q);
          out_last_d = 1'b1;
          pend_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.set_index = out_set_q;
  assign out_o.line_tag  = out_tag_q;
  assign out_o.line_data = out_data_q;
  assign out_o.read_byte = out_byte_q;
  assign out_o.last      = out_last_q;

  // a line write outside the clearing pass always reports the written line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != ST_CLEAR)) |-> (out_load && (out_kind_d == KIND_WRITTEN)))
    else $error("line write without written-line result");

  // a victim report is never the final result of its write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_kind_d == KIND_EVICT)) |-> !out_last_d)
    else $error("evicted line flagged last");

  // a pending result is never overwritten while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !out_load)
    else $error("output register overwritten under stall");

  // a held dump line exists only while a dump is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((state_q == ST_DUMP) || (state_q == ST_DUMP_END)))
    else $error("dump line held outside a dump");

  // a dump never takes more lines than it may report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("dump line count overflow");

endmodule
